// ===== rtl/core/lrupr_pkg.sv =====
// Package for the LRU page replacement block.
// Holds sizes, the recency-chain entry types and the result record.
// Used by every module under rtl/core.
`timescale 1ns / 1ps

package lrupr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 8;
	localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int CFG_W     = 4;
	localparam int FAULT_W   = 16;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = CFG_W'(3);
	localparam logic [FAULT_W-1:0] FAULT_MAX         = {FAULT_W{1'b1}};

	typedef struct packed {
		logic [SLOT_W-1:0]    slot;
		logic [PAGE_BITS-1:0] page;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic elig;
	} cell_stat_t;

	typedef struct packed {
		logic                 fault;
		logic [SLOT_W-1:0]    slot;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_total;
	} result_t;

endpackage

// ===== rtl/core/lrupr_cell.sv =====
// One position of the recency chain: holds a slot number and its page.
// Compares its page with the request and takes its neighbor's entry on a shift.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lrupr_pkg::cell_ctl_t           ctl,
	input  logic                           prev_valid,
	input  lrupr_pkg::entry_t              prev,
	input  logic [lrupr_pkg::PAGE_BITS-1:0] req_page,
	input  logic [lrupr_pkg::CNT_W-1:0]    frames_n,
	output lrupr_pkg::cell_stat_t          stat,
	output lrupr_pkg::entry_t              entry
);
	import lrupr_pkg::*;

	logic   valid_q;
	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= prev;
		end
	end

	always_comb begin
		stat.valid = valid_q;
		stat.elig  = valid_q && (CNT_W'(entry_q.slot) < frames_n);
		stat.hit   = stat.elig && (entry_q.page == req_page);
	end

	assign entry = entry_q;

endmodule

// ===== rtl/core/lrupr_out_buf.sv =====
// Result register with a skid stage, so a request is taken while a result waits.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lrupr_pkg::result_t  push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output lrupr_pkg::result_t  pop_data
);
	import lrupr_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    push;
	logic    pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign pop        = out_valid_q && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push && out_valid_q && !pop) begin
			skid_valid_q <= 1'b1;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push && out_valid_q && !pop) begin
			skid_q <= push_data;
		end else if (push) begin
			out_q <= push_data;
		end
	end

	assign pop_valid = out_valid_q;
	assign pop_data  = out_q;

endmodule

// ===== rtl/core/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: recency chain, decision logic,
// fault counter and result buffer. Depends on lrupr_pkg, lrupr_cell, lrupr_out_buf.
//
//   Channel   Handshake                 Payload
//   request   req_valid / req_ready     page, end_of_string
//   result    res_valid / res_ready     fault, slot, evicted_valid, evicted_page,
//                                       fault_total
//   config    cfg_write_en              cfg_write_data (frame count)
//
// One request is taken per cycle while req_ready is high; its result is registered before it appears.
// The cell chain is ordered by recency and updates in the cycle of acceptance.
// A result register plus a skid entry decouple the sides; req_ready falls only
// when both are full. Reset clears the chain and counters and sets the frame count to 3.
`timescale 1ns / 1ps

module lru_page_replacement_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [lrupr_pkg::PAGE_BITS-1:0] page,
	input  logic                            end_of_string,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            fault,
	output logic [lrupr_pkg::SLOT_W-1:0]    slot,
	output logic                            evicted_valid,
	output logic [lrupr_pkg::PAGE_BITS-1:0] evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]   fault_total,
	input  logic                            cfg_write_en,
	input  logic [lrupr_pkg::CFG_W-1:0]     cfg_write_data
);
	import lrupr_pkg::*;

	logic [CFG_W-1:0]   frame_count_q;
	logic [CNT_W-1:0]   fill_pointer_q;
	logic [FAULT_W-1:0] fault_count_q;

	logic [CNT_W-1:0]   frames_n;
	logic               accept;
	cell_ctl_t          ctl      [FRAMES];
	cell_stat_t         stat     [FRAMES];
	entry_t             entries  [FRAMES];
	logic               pv       [FRAMES];
	entry_t             prev     [FRAMES];
	logic [FRAMES-1:0]  valid_vec;

	logic [FRAMES-1:0]    hit_by_slot;
	logic                 hit;
	logic [SLOT_W-1:0]    hit_slot;
	logic [SLOT_W-1:0]    hit_pos;
	logic [SLOT_W-1:0]    evict_pos;
	logic [SLOT_W-1:0]    evict_slot;
	logic [PAGE_BITS-1:0] evict_page;
	logic                 fill;
	logic [SLOT_W-1:0]    sel_pos;
	logic [SLOT_W-1:0]    new_slot;
	logic [FAULT_W-1:0]   fault_next;
	result_t              res;
	result_t              res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg_write_en) begin
			frame_count_q <= cfg_write_data;
		end
	end

	always_comb begin
		if (frame_count_q == '0) begin
			frames_n = CNT_W'(1);
		end else if (32'(frame_count_q) > FRAMES) begin
			frames_n = CNT_W'(FRAMES);
		end else begin
			frames_n = CNT_W'(frame_count_q);
		end
	end

	assign accept = req_valid && req_ready;

	for (genvar k = 0; k < FRAMES; k++) begin : g_chain
		if (k == 0) begin : g_head
			assign pv[k]   = 1'b1;
			assign prev[k] = '{slot: new_slot, page: page};
		end else begin : g_body
			assign pv[k]   = stat[k-1].valid;
			assign prev[k] = entries[k-1];
		end

		assign ctl[k].shift = accept && (SLOT_W'(k) <= sel_pos);
		assign ctl[k].clear = accept && end_of_string;
		assign valid_vec[k] = stat[k].valid;

		lrupr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[k]),
			.prev_valid (pv[k]),
			.prev       (prev[k]),
			.req_page   (page),
			.frames_n   (frames_n),
			.stat       (stat[k]),
			.entry      (entries[k])
		);
	end

	always_comb begin
		hit_by_slot = '0;
		for (int s = 0; s < FRAMES; s++) begin
			for (int k = 0; k < FRAMES; k++) begin
				if (stat[k].hit && (entries[k].slot == SLOT_W'(s))) begin
					hit_by_slot[s] = 1'b1;
				end
			end
		end

		hit      = |hit_by_slot;
		hit_slot = '0;
		for (int s = FRAMES - 1; s >= 0; s--) begin
			if (hit_by_slot[s]) begin
				hit_slot = SLOT_W'(s);
			end
		end

		hit_pos    = '0;
		evict_pos  = '0;
		evict_slot = '0;
		evict_page = '0;
		for (int k = 0; k < FRAMES; k++) begin
			if (stat[k].hit && (entries[k].slot == hit_slot)) begin
				hit_pos = SLOT_W'(k);
			end
			if (stat[k].elig) begin
				evict_pos  = SLOT_W'(k);
				evict_slot = entries[k].slot;
				evict_page = entries[k].page;
			end
		end

		fill = !hit && (fill_pointer_q < frames_n);

		if (hit) begin
			sel_pos  = hit_pos;
			new_slot = hit_slot;
		end else if (fill) begin
			sel_pos  = fill_pointer_q[SLOT_W-1:0];
			new_slot = fill_pointer_q[SLOT_W-1:0];
		end else begin
			sel_pos  = evict_pos;
			new_slot = evict_slot;
		end

		if (!hit && (fault_count_q != FAULT_MAX)) begin
			fault_next = fault_count_q + FAULT_W'(1);
		end else begin
			fault_next = fault_count_q;
		end

		res.fault         = !hit;
		res.slot          = new_slot;
		res.evicted_valid = !hit && !fill;
		res.evicted_page  = (!hit && !fill) ? evict_page : '0;
		res.fault_total   = fault_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_pointer_q <= '0;
			fault_count_q  <= '0;
		end else if (accept) begin
			if (end_of_string) begin
				fill_pointer_q <= '0;
				fault_count_q  <= '0;
			end else begin
				fill_pointer_q <= fill ? fill_pointer_q + CNT_W'(1) : fill_pointer_q;
				fault_count_q  <= fault_next;
			end
		end
	end

	lrupr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req_valid),
		.push_ready (req_ready),
		.push_data  (res),
		.pop_valid  (res_valid),
		.pop_ready  (res_ready),
		.pop_data   (res_out)
	);

	assign fault         = res_out.fault;
	assign slot          = res_out.slot;
	assign evicted_valid = res_out.evicted_valid;
	assign evicted_page  = res_out.evicted_page;
	assign fault_total   = res_out.fault_total;

	// The valid cells always form the head of the chain, one per filled slot.
	a_fill_matches_chain : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_pointer_q))
		else $error("valid cells do not match fill pointer");

	a_fill_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_pointer_q) <= FRAMES)
		else $error("fill pointer beyond frame count");

	// Replacement happens only once every frame in use has been filled.
	a_evict_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.evicted_valid |-> fill_pointer_q >= frames_n)
		else $error("eviction while empty frames remain");

	a_end_clears : assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_string |=> (fill_pointer_q == '0) && (fault_count_q == '0)
			&& (valid_vec == '0))
		else $error("end of string did not clear the table");

endmodule

// ===== tb/lru_page_replacement_top_tb.sv =====
// Self-checking testbench for lru_page_replacement_top: drives page requests, predicts
// fault, slot, eviction and fault total with its own LRU table, and checks every result.
// Depends on lrupr_pkg and the block's RTL.
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;
	import lrupr_pkg::*;

	typedef struct {
		logic [PAGE_BITS-1:0] pg;
		logic                 last;
	} page_ref_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [PAGE_BITS-1:0] page = '0;
	logic                 end_of_string = 1'b0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic                 fault;
	logic [SLOT_W-1:0]    slot;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [FAULT_W-1:0]   fault_total;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_W-1:0]     cfg_write_data = '0;

	page_ref_t ref_pending[$];
	page_ref_t drv_ref;
	result_t   outcome_q[$];
	result_t   want;

	logic [PAGE_BITS-1:0] tbl_page[FRAMES];
	logic                 tbl_valid[FRAMES];
	int                   tbl_age[FRAMES];
	int                   next_fill;
	logic [FAULT_W-1:0]   faults_so_far;
	logic [CFG_W-1:0]     frames_cfg = FRAME_COUNT_RESET;

	int   send_idle = 0;
	int   recv_stall = 0;
	int   rx_hold = 0;
	logic req_taken = 1'b0;
	int   items_queued = 0;
	int   results_seen = 0;
	int   errors = 0;

	lru_page_replacement_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.page           (page),
		.end_of_string  (end_of_string),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.fault          (fault),
		.slot           (slot),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_total    (fault_total),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: %s", $realtime, msg);
	endtask

	function automatic void forget_string();
		for (int i = 0; i < FRAMES; i++) begin
			tbl_page[i] = '0;
			tbl_valid[i] = 1'b0;
			tbl_age[i] = 0;
		end
		next_fill = 0;
		faults_so_far = '0;
	endfunction

	function automatic void promote(input int s, input int limit);
		for (int i = 0; i < FRAMES; i++)
			if (i != s && tbl_valid[i] && tbl_age[i] < limit)
				tbl_age[i]++;
		tbl_age[s] = 0;
	endfunction

	function automatic result_t lru_reference(input logic [PAGE_BITS-1:0] pg, input logic last);
		result_t r;
		int      n;
		int      sl;
		logic    hit;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
		hit = 1'b0;
		sl = 0;
		r = '0;
		for (int i = 0; i < n; i++) begin
			if (!hit && tbl_valid[i] && tbl_page[i] == pg) begin
				hit = 1'b1;
				sl = i;
			end
		end
		if (hit) begin
			promote(sl, tbl_age[sl]);
		end else begin
			if (next_fill < n) begin
				sl = next_fill;
				next_fill++;
				promote(sl, 255);
			end else begin
				for (int i = 1; i < n; i++)
					if (tbl_age[i] > tbl_age[sl])
						sl = i;
				r.evicted_valid = 1'b1;
				r.evicted_page = tbl_page[sl];
				promote(sl, tbl_age[sl]);
			end
			tbl_page[sl] = pg;
			tbl_valid[sl] = 1'b1;
			if (faults_so_far != FAULT_MAX)
				faults_so_far++;
		end
		r.fault = !hit;
		r.slot = sl[SLOT_W-1:0];
		r.fault_total = faults_so_far;
		if (last)
			forget_string();
		return r;
	endfunction

	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (ref_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				drv_ref = ref_pending.pop_front();
				req_valid <= 1'b1;
				page <= drv_ref.pg;
				end_of_string <= drv_ref.last;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		req_taken = arst_n && req_valid && req_ready;
		if (req_taken)
			outcome_q.push_back(lru_reference(page, end_of_string));
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (outcome_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = outcome_q.pop_front();
				if (fault !== want.fault)
					report_mismatch($sformatf("fault: got %0b, expected %0b",
						fault, want.fault));
				if (slot !== want.slot)
					report_mismatch($sformatf("slot: got %0d, expected %0d",
						slot, want.slot));
				if (evicted_valid !== want.evicted_valid)
					report_mismatch($sformatf("evicted_valid: got %0b, expected %0b",
						evicted_valid, want.evicted_valid));
				if (evicted_page !== want.evicted_page)
					report_mismatch($sformatf("evicted_page: got %0d, expected %0d",
						evicted_page, want.evicted_page));
				if (fault_total !== want.fault_total)
					report_mismatch($sformatf("fault_total: got %0d, expected %0d",
						fault_total, want.fault_total));
			end
		end
	end

	task automatic add_ref(input logic [PAGE_BITS-1:0] pg, input logic last);
		page_ref_t r;
		r.pg = pg;
		r.last = last;
		ref_pending.push_back(r);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (results_seen != items_queued)
			@(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] fc);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= fc;
		frames_cfg = fc;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_strings(input int n);
		logic [PAGE_BITS-1:0] pool[10];
		logic [PAGE_BITS-1:0] pg;
		int                   pool_n;
		int                   len;
		int                   k;
		k = 0;
		while (k < n) begin
			pool_n = $urandom_range(1, 10);
			foreach (pool[j])
				pool[j] = PAGE_BITS'($urandom_range(0, 255));
			len = $urandom_range(1, 40);
			for (int j = 0; j < len && k < n; j++) begin
				if ($urandom_range(9) == 0)
					pg = PAGE_BITS'($urandom_range(0, 255));
				else
					pg = pool[$urandom_range(0, pool_n - 1)];
				add_ref(pg, (j == len - 1) || ($urandom_range(49) == 0));
				k++;
			end
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] fc, input int s_pct, input int r_pct,
			input int hold, input int n);
		write_frames(fc);
		send_idle = s_pct;
		recv_stall = r_pct;
		rx_hold = hold;
		queue_strings(n);
		wait_drained();
	endtask

	initial begin
		forget_string();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		add_ref(8'd0, 1'b0);
		add_ref(8'd255, 1'b0);
		add_ref(8'd0, 1'b0);
		add_ref(8'd170, 1'b0);
		add_ref(8'd85, 1'b0);
		add_ref(8'd255, 1'b0);
		add_ref(8'd0, 1'b1);
		add_ref(8'd128, 1'b1);
		wait_drained();

		write_frames(4'd0);
		add_ref(8'd1, 1'b0);
		add_ref(8'd2, 1'b0);
		add_ref(8'd1, 1'b1);
		wait_drained();

		write_frames(4'd15);
		for (int i = 10; i <= 18; i++)
			add_ref(i[PAGE_BITS-1:0], 1'b0);
		add_ref(8'd10, 1'b1);
		wait_drained();

		// Shrink the frame count mid-string, then grow it back.
		write_frames(4'd8);
		for (int i = 20; i <= 23; i++)
			add_ref(i[PAGE_BITS-1:0], 1'b0);
		wait_drained();
		write_frames(4'd2);
		add_ref(8'd23, 1'b0);
		wait_drained();
		write_frames(4'd8);
		add_ref(8'd23, 1'b1);
		wait_drained();

		run_phase(4'd0, 0, 0, 0, 150);
		run_phase(4'd8, 58, 0, 0, 200);
		run_phase(4'd15, 0, 58, 0, 200);
		run_phase(4'd2, 19, 19, 0, 200);
		run_phase(4'd5, 0, 0, 80, 150);
		run_phase(4'd9, 19, 19, 0, 200);
		run_phase(4'd4, 58, 0, 0, 150);
		run_phase(4'd6, 0, 0, 0, 150);
		run_phase(4'd7, 0, 58, 0, 200);

		repeat (10) @(negedge clk);
		if (outcome_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_cell.sv
rtl/core/lrupr_out_buf.sv
rtl/core/lru_page_replacement_top.sv
tb/lru_page_replacement_top_tb.sv
